FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("implication check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: src/imutfd_pkg.sv
// Types, constants and helpers of the tagged FIFO decompressor.
`default_nettype none
package imutfd_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);

    localparam logic [15:0] AXIS_DEFAULT = 16'h7FFF;
    localparam logic [47:0] AXES_DEFAULT = {3{AXIS_DEFAULT}};

    localparam logic REG_COMP_AT_START = 1'b0;

    localparam logic [4:0] TAG_GYRO      = 5'h01;
    localparam logic [4:0] TAG_ACC       = 5'h02;
    localparam logic [4:0] TAG_TEMP      = 5'h03;
    localparam logic [4:0] TAG_TIME      = 5'h04;
    localparam logic [4:0] TAG_CFG       = 5'h05;
    localparam logic [4:0] TAG_ACC_T2    = 5'h06;
    localparam logic [4:0] TAG_ACC_T1    = 5'h07;
    localparam logic [4:0] TAG_ACC_2X8   = 5'h08;
    localparam logic [4:0] TAG_ACC_3X5   = 5'h09;
    localparam logic [4:0] TAG_GYRO_T2   = 5'h0A;
    localparam logic [4:0] TAG_GYRO_T1   = 5'h0B;
    localparam logic [4:0] TAG_GYRO_2X8  = 5'h0C;
    localparam logic [4:0] TAG_GYRO_3X5  = 5'h0D;
    localparam logic [4:0] TAG_NI_FIRST  = 5'h0E;
    localparam logic [4:0] TAG_NI_LAST   = 5'h12;
    localparam logic [4:0] TAG_NI_EXTRA  = 5'h19;

    typedef enum logic [1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_PARITY   = 2'd1,
        KIND_NOT_IMPL = 2'd2,
        KIND_UNKNOWN  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REL_RD,
        ST_REL_OUT,
        ST_DEC,
        ST_CHAIN,
        ST_ERR_OUT
    } t_state;

    typedef struct packed {
        logic [7:0] tag_byte;
        logic [7:0] x_low;
        logic [7:0] x_high;
        logic [7:0] y_low;
        logic [7:0] y_high;
        logic [7:0] z_low;
        logic [7:0] z_high;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        sample_index;
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] temp_raw;
        logic [63:0]        stamp;
        logic [1:0]         extras_valid;
        logic               last;
    } t_out_item;

    // axes packed z:y:x, 16 bits each
    typedef struct packed {
        logic [47:0] acc;
        logic [47:0] gyro;
        logic [15:0] temp;
        logic [63:0] stamp;
        logic [31:0] cnt;
        logic        ftemp;
        logic        ftime;
    } t_slot;

    typedef struct packed {
        logic acc;
        logic gyro;
        logic temp;
        logic stamp;
        logic cnt;
        logic ftemp;
        logic ftime;
    } t_slot_we;

    function automatic logic [15:0] sx8(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

    function automatic logic [15:0] sx5(input logic [4:0] v);
        return {{11{v[4]}}, v};
    endfunction

    function automatic logic [47:0] add_axes(input logic [47:0] base,
                                             input logic [15:0] dx,
                                             input logic [15:0] dy,
                                             input logic [15:0] dz);
        return {base[47:32] + dz, base[31:16] + dy, base[15:0] + dx};
    endfunction

    function automatic t_kind tag_kind(input logic [4:0] tag);
        t_kind k;
        if (tag >= TAG_GYRO && tag <= TAG_GYRO_3X5) begin
            k = KIND_SAMPLE;
        end else if ((tag >= TAG_NI_FIRST && tag <= TAG_NI_LAST) || tag == TAG_NI_EXTRA) begin
            k = KIND_NOT_IMPL;
        end else begin
            k = KIND_UNKNOWN;
        end
        return k;
    endfunction

endpackage
`default_nettype wire

FILE: src/imutfd_slot_ram.sv
// Slot memory: one entry per time slot, field write enables, registered read.
`default_nettype none
module imutfd_slot_ram
    import imutfd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire t_slot_we             i_we,
    input  wire logic [SLOT_BITS-1:0] i_waddr,
    input  wire t_slot                i_wdata,
    input  wire logic                 i_re,
    input  wire logic [SLOT_BITS-1:0] i_raddr,
    output t_slot                     o_rdata
);

    t_slot r_mem [SLOT_COUNT];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we.acc)   r_mem[i_waddr].acc   <= i_wdata.acc;
        if (i_we.gyro)  r_mem[i_waddr].gyro  <= i_wdata.gyro;
        if (i_we.temp)  r_mem[i_waddr].temp  <= i_wdata.temp;
        if (i_we.stamp) r_mem[i_waddr].stamp <= i_wdata.stamp;
        if (i_we.cnt)   r_mem[i_waddr].cnt   <= i_wdata.cnt;
        if (i_we.ftemp) r_mem[i_waddr].ftemp <= i_wdata.ftemp;
        if (i_we.ftime) r_mem[i_waddr].ftime <= i_wdata.ftime;
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: src/imu_tagged_fifo_decompressor.sv
// Top level of the tagged sensor FIFO word decompressor.
`default_nettype none
`include "assert_macros.svh"
// Takes one 7-byte tagged FIFO word per transfer and returns zero to five
// result transfers. After reset a clearing pass loads each slot of the
// slot memory and no word is taken meanwhile. A word is then accepted, each
// released slot is read from memory, then output and written back, the
// release scan ends, and the word is decoded; delta-compressed words then
// update their slots (T-2 and T-1 for the 8-bit pair, also T for the 5-bit
// triple) by chained read-modify-write. A word with a parity error skips
// the scan and gives one error result; an error tag adds one error result
// after the releases. Release and decode share the slot memory's read and
// write ports; a result waiting at the output stalls the sequencer.
module imu_tagged_fifo_decompressor
    import imutfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_state r_state, n_state;
    logic [SLOT_BITS-1:0] r_clr_idx, n_clr_idx;
    t_in_item r_word, n_word;
    logic [31:0] r_running, n_running;
    logic [31:0] r_release, n_release;
    logic r_started, n_started;
    logic [63:0] r_time_ext, n_time_ext;
    logic r_comp, n_comp;
    logic r_cfg, n_cfg;
    logic [2:0] r_nrel, n_nrel;
    logic [1:0] r_k, n_k;
    logic [47:0] r_chain, n_chain;
    t_kind r_kind, n_kind;
    t_out_item r_out, n_out;
    logic r_out_vld, n_out_vld;

    t_slot_we ram_we;
    logic [SLOT_BITS-1:0] ram_waddr, ram_raddr;
    t_slot ram_wdata, ram_rdata;
    logic ram_re;

    logic cfg_wr, out_free, out_load;
    logic [31:0] backlog, backlog_next;
    logic rel_more, rel_pend;
    logic [4:0] tag;
    logic [SLOT_BITS-1:0] slot_t;
    logic [1:0] in_tc;
    logic [31:0] base_run, base_rel;
    logic [29:0] run_hi;
    logic [63:0] ts_new;
    logic [47:0] chain_base, chain_sum;
    logic [15:0] d0, d1, d2;
    logic chain_last;
    logic [1:0] chain_back;
    logic is_triple, is_gyro_chain, parity_bad;

    imutfd_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COMP_AT_START) ? {31'd0, r_cfg} : 32'd0;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_vld || i_out_ready;

    assign tag    = r_word.tag_byte[7:3];
    assign slot_t = r_running[SLOT_BITS-1:0];

    assign backlog      = r_running - r_release;
    assign backlog_next = r_running - (r_release + 32'd1);
    assign rel_pend = (r_nrel < 3'(SLOT_COUNT)) && (r_comp ? (backlog > 32'd2) : (backlog != 32'd0));
    assign rel_more = ((r_nrel + 3'd1) < 3'(SLOT_COUNT)) &&
                      (r_comp ? (backlog_next > 32'd2) : (backlog_next != 32'd0));

    // counter extension on an accepted word
    assign parity_bad = ^i_in_data.tag_byte;
    assign in_tc      = i_in_data.tag_byte[2:1];
    assign base_run   = r_started ? r_running : {30'd0, in_tc};
    assign base_rel   = r_started ? r_release : {30'd0, in_tc};
    assign run_hi     = (in_tc < base_run[1:0]) ? base_run[31:2] + 30'd1 : base_run[31:2];

    // timestamp extension
    assign ts_new = {(r_time_ext[31:0] > {r_word.y_high, r_word.y_low, r_word.x_high,
                     r_word.x_low}) ? r_time_ext[63:32] + 32'd1 : r_time_ext[63:32],
                     r_word.y_high, r_word.y_low, r_word.x_high, r_word.x_low};

    // delta chain
    assign is_triple     = (tag == TAG_ACC_3X5) || (tag == TAG_GYRO_3X5);
    assign is_gyro_chain = (tag == TAG_GYRO_2X8) || (tag == TAG_GYRO_3X5);
    assign chain_base    = (r_k == 2'd0) ? (is_gyro_chain ? ram_rdata.gyro : ram_rdata.acc)
                                         : r_chain;
    assign chain_last    = is_triple ? (r_k == 2'd2) : (r_k == 2'd1);
    assign chain_back    = 2'd2 - r_k;

    always_comb begin
        logic [7:0] lo, hi;
        lo = r_word.x_low;
        hi = r_word.x_high;
        case (r_k)
            2'd1:    begin lo = r_word.y_low; hi = r_word.y_high; end
            2'd2:    begin lo = r_word.z_low; hi = r_word.z_high; end
            default: begin lo = r_word.x_low; hi = r_word.x_high; end
        endcase
        if (is_triple) begin
            d0 = sx5(lo[4:0]);
            d1 = sx5({hi[1:0], lo[7:5]});
            d2 = sx5(hi[6:2]);
        end else if (r_k == 2'd0) begin
            d0 = sx8(r_word.x_low);
            d1 = sx8(r_word.x_high);
            d2 = sx8(r_word.y_low);
        end else begin
            d0 = sx8(r_word.y_high);
            d1 = sx8(r_word.z_low);
            d2 = sx8(r_word.z_high);
        end
    end

    assign chain_sum = add_axes(chain_base, d0, d1, d2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_idx  <= '0;
            r_running  <= '0;
            r_release  <= '0;
            r_started  <= 1'b0;
            r_time_ext <= '0;
            r_comp     <= 1'b0;
            r_cfg      <= 1'b0;
            r_nrel     <= '0;
            r_k        <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_idx  <= n_clr_idx;
            r_running  <= n_running;
            r_release  <= n_release;
            r_started  <= n_started;
            r_time_ext <= n_time_ext;
            r_comp     <= n_comp;
            r_cfg      <= n_cfg;
            r_nrel     <= n_nrel;
            r_k        <= n_k;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_chain <= n_chain;
        r_kind  <= n_kind;
        r_out   <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        n_word     = r_word;
        n_running  = r_running;
        n_release  = r_release;
        n_started  = r_started;
        n_time_ext = r_time_ext;
        n_comp     = r_comp;
        n_cfg      = r_cfg;
        n_nrel     = r_nrel;
        n_k        = r_k;
        n_chain    = r_chain;
        n_kind     = r_kind;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !i_out_ready;
        out_load   = 1'b0;
        ram_we     = '0;
        ram_waddr  = slot_t;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = r_release[SLOT_BITS-1:0];

        if (cfg_wr && paddr[2] == REG_COMP_AT_START) begin
            n_cfg  = pwdata[0];
            n_comp = pwdata[0];
        end

        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = '1;
                ram_waddr = r_clr_idx;
                ram_wdata = '{acc: AXES_DEFAULT, gyro: AXES_DEFAULT, default: '0};
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == SLOT_BITS'(SLOT_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_word = i_in_data;
                    if (parity_bad) begin
                        n_kind  = KIND_PARITY;
                        n_state = ST_ERR_OUT;
                    end else begin
                        n_started = 1'b1;
                        n_running = {run_hi, in_tc};
                        n_release = base_rel;
                        n_nrel    = '0;
                        n_state   = ST_REL_RD;
                    end
                end
            end
            ST_REL_RD: begin
                if (rel_pend) begin
                    ram_re  = 1'b1;
                    n_state = ST_REL_OUT;
                end else begin
                    n_state = ST_DEC;
                end
            end
            ST_REL_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_out_vld = 1'b1;
                    n_out = '{kind: KIND_SAMPLE, sample_index: ram_rdata.cnt,
                              acc_x: ram_rdata.acc[15:0], acc_y: ram_rdata.acc[31:16],
                              acc_z: ram_rdata.acc[47:32],
                              gyro_x: ram_rdata.gyro[15:0], gyro_y: ram_rdata.gyro[31:16],
                              gyro_z: ram_rdata.gyro[47:32],
                              temp_raw: ram_rdata.temp, stamp: ram_rdata.stamp,
                              extras_valid: {ram_rdata.ftemp, ram_rdata.ftime},
                              last: !rel_more && (tag_kind(tag) == KIND_SAMPLE)};
                    // clear the slot; keep axes as delta bases with compression on
                    ram_we    = '{acc: !r_comp, gyro: !r_comp, default: 1'b1};
                    ram_waddr = r_release[SLOT_BITS-1:0];
                    ram_wdata = '{acc: AXES_DEFAULT, gyro: AXES_DEFAULT, default: '0};
                    n_release = r_release + 32'd1;
                    n_nrel    = r_nrel + 3'd1;
                    n_state   = ST_REL_RD;
                end
            end
            ST_DEC: begin
                n_state   = ST_IDLE;
                ram_wdata = '{acc: {r_word.z_high, r_word.z_low, r_word.y_high, r_word.y_low,
                                    r_word.x_high, r_word.x_low},
                              gyro: {r_word.z_high, r_word.z_low, r_word.y_high,
                                     r_word.y_low, r_word.x_high, r_word.x_low},
                              temp: {r_word.x_high, r_word.x_low},
                              stamp: ts_new, cnt: r_running, ftemp: 1'b1, ftime: 1'b1};
                case (tag)
                    TAG_GYRO: ram_we = '{gyro: 1'b1, cnt: 1'b1, default: 1'b0};
                    TAG_ACC:  ram_we = '{acc: 1'b1, cnt: 1'b1, default: 1'b0};
                    TAG_TEMP: ram_we = '{temp: 1'b1, ftemp: 1'b1, default: 1'b0};
                    TAG_TIME: begin
                        ram_we     = '{stamp: 1'b1, ftime: 1'b1, default: 1'b0};
                        n_time_ext = ts_new;
                    end
                    TAG_CFG: n_comp = r_word.y_high[7];
                    TAG_ACC_T2, TAG_ACC_T1: begin
                        ram_we = '{acc: 1'b1, cnt: 1'b1, default: 1'b0};
                        ram_waddr = (tag == TAG_ACC_T2) ? slot_t - SLOT_BITS'(2)
                                                        : slot_t - SLOT_BITS'(1);
                        ram_wdata.cnt = (tag == TAG_ACC_T2) ? r_running - 32'd2
                                                            : r_running - 32'd1;
                    end
                    TAG_GYRO_T2, TAG_GYRO_T1: begin
                        ram_we = '{gyro: 1'b1, cnt: 1'b1, default: 1'b0};
                        ram_waddr = (tag == TAG_GYRO_T2) ? slot_t - SLOT_BITS'(2)
                                                         : slot_t - SLOT_BITS'(1);
                        ram_wdata.cnt = (tag == TAG_GYRO_T2) ? r_running - 32'd2
                                                             : r_running - 32'd1;
                    end
                    TAG_ACC_2X8, TAG_ACC_3X5, TAG_GYRO_2X8, TAG_GYRO_3X5: begin
                        // fetch the base at slot T-3
                        ram_re    = 1'b1;
                        ram_raddr = slot_t - SLOT_BITS'(3);
                        n_k       = 2'd0;
                        n_state   = ST_CHAIN;
                    end
                    default: begin
                        n_kind  = tag_kind(tag);
                        n_state = ST_ERR_OUT;
                    end
                endcase
            end
            ST_CHAIN: begin
                ram_we    = '{acc: !is_gyro_chain, gyro: is_gyro_chain, cnt: 1'b1,
                              default: 1'b0};
                ram_waddr = slot_t - SLOT_BITS'(chain_back);
                ram_wdata = '{acc: chain_sum, gyro: chain_sum,
                              cnt: r_running - 32'(chain_back), default: '0};
                n_chain   = chain_sum;
                n_k       = r_k + 2'd1;
                if (chain_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ERR_OUT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    n_out_vld = 1'b1;
                    n_out     = '0;
                    n_out.kind = r_kind;
                    n_out.last = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `ASSERT_NEVER(a_ram_rw_same, i_clk, i_rst_n, ram_re && (|ram_we) && ram_raddr == ram_waddr)
    `ASSERT_NEVER(a_out_overrun, i_clk, i_rst_n, out_load && r_out_vld && !i_out_ready)
    `ASSERT_IMPLIES(a_parity_hold, i_clk, i_rst_n, (o_in_ready && i_in_valid && parity_bad) |=> ($stable(r_running) && $stable(r_release)))
    `ASSERT_NEVER(a_rel_limit, i_clk, i_rst_n, r_nrel > 3'(SLOT_COUNT))

endmodule
`default_nettype wire

FILE: sim/imu_tagged_fifo_decompressor_tb.sv
// Testbench for the tagged sensor FIFO word decompressor: directed table, then random phases.
module imu_tagged_fifo_decompressor_tb;
    import imutfd_pkg::*;

    localparam int LIMIT = 600000;

    typedef struct packed {
        logic [4:0]  tag;
        logic [1:0]  cnt;
        logic [47:0] data;   // x_low, x_high, y_low, y_high, z_low, z_high
        logic        bad;
        logic        typed;
        t_kind       tk;
    } t_row;

    typedef struct {
        t_in_item   w;
        logic       typed;
        logic [1:0] tk;
    } t_word;

    localparam int NROWS = 23;
    localparam t_row DIR_ROWS [NROWS] = '{
        '{TAG_ACC,      2'd0, 48'h000000000000, 1'b1, 1'b1, KIND_PARITY},
        '{TAG_ACC,      2'd0, 48'hFFFFFFFFFFFF, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_GYRO,     2'd0, 48'h000000000000, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_TEMP,     2'd0, 48'h008000000000, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_TIME,     2'd0, 48'hFFFFFFFF0000, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_ACC,      2'd1, 48'hFF7F00800100, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_TIME,     2'd1, 48'h010000000000, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_ACC_T2,   2'd2, 48'h123456789ABC, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_ACC_T1,   2'd2, 48'hFEDCBA987654, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_GYRO_T2,  2'd3, 48'h00FF00FF00FF, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_GYRO_T1,  2'd3, 48'hFF00FF00FF00, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_CFG,      2'd0, 48'h000000800000, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_ACC_2X8,  2'd1, 48'h807F01FF8000, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_GYRO_2X8, 2'd2, 48'h7F80FF017F80, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_ACC_3X5,  2'd3, 48'hFFFFFFFFFFFF, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_GYRO_3X5, 2'd0, 48'h107C0F7CE003, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_NI_FIRST, 2'd0, 48'h000000000000, 1'b0, 1'b1, KIND_NOT_IMPL},
        '{TAG_NI_LAST,  2'd1, 48'h000000000000, 1'b0, 1'b1, KIND_NOT_IMPL},
        '{TAG_NI_EXTRA, 2'd1, 48'h000000000000, 1'b0, 1'b1, KIND_NOT_IMPL},
        '{5'h1F,        2'd2, 48'h000000000000, 1'b0, 1'b1, KIND_UNKNOWN},
        '{5'h00,        2'd2, 48'h000000000000, 1'b0, 1'b1, KIND_UNKNOWN},
        '{TAG_CFG,      2'd3, 48'hFFFFFF7FFFFF, 1'b0, 1'b0, KIND_SAMPLE},
        '{TAG_ACC,      2'd1, 48'h55AA55AA55AA, 1'b0, 1'b0, KIND_SAMPLE}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic [31:0] prdata;
    logic        pready;

    imu_tagged_fifo_decompressor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // decoder image: axes[0] accel, axes[1] gyro
    logic [15:0] axes [2][SLOT_COUNT][3];
    logic [15:0] temp_s [SLOT_COUNT];
    logic [63:0] stamp_s [SLOT_COUNT];
    logic [31:0] index_s [SLOT_COUNT];
    logic [1:0]  flags_s [SLOT_COUNT];
    logic [31:0] sample_cnt, released_cnt;
    logic        cnt_started, comp_on;
    logic [63:0] stamp_ext;

    t_word     word_q [$];
    t_out_item sample_q [$];
    int        send_idle = 0, recv_stall = 0;
    int        fails = 0;
    int        cyc = 0;

    function automatic logic [15:0] ext8(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

    function automatic logic [15:0] ext5(input logic [4:0] v);
        return {{11{v[4]}}, v};
    endfunction

    task automatic reset_image();
        for (int s = 0; s < SLOT_COUNT; s++) begin
            for (int k = 0; k < 3; k++) begin
                axes[0][s][k] = AXIS_DEFAULT;
                axes[1][s][k] = AXIS_DEFAULT;
            end
            temp_s[s] = '0;
            stamp_s[s] = '0;
            index_s[s] = '0;
            flags_s[s] = '0;
        end
        sample_cnt = '0;
        released_cnt = '0;
        cnt_started = 1'b0;
        stamp_ext = '0;
        comp_on = 1'b0;
    endtask

    task automatic load_plain(input int k, input int s, input logic [7:0] d [6],
                              input logic [31:0] c);
        axes[k][s][0] = {d[1], d[0]};
        axes[k][s][1] = {d[3], d[2]};
        axes[k][s][2] = {d[5], d[4]};
        index_s[s] = c;
    endtask

    task automatic add5(input int k, input int dst, input int src,
                        input logic [7:0] hi, input logic [7:0] lo);
        axes[k][dst][0] = axes[k][src][0] + ext5(lo[4:0]);
        axes[k][dst][1] = axes[k][src][1] + ext5({hi[1:0], lo[7:5]});
        axes[k][dst][2] = axes[k][src][2] + ext5(hi[6:2]);
    endtask

    // Work out the results of one accepted word and queue them.
    task automatic decode_word(input t_word item);
        t_out_item   res [5];
        int          n;
        int          s, t, t1, t2, t3, k;
        logic [7:0]  tb;
        logic [4:0]  tag;
        logic [1:0]  tc;
        logic [7:0]  d [6];
        logic [31:0] lag, ts;
        logic [1:0]  kind;
        n = 0;
        tb = item.w.tag_byte;
        d[0] = item.w.x_low;  d[1] = item.w.x_high;
        d[2] = item.w.y_low;  d[3] = item.w.y_high;
        d[4] = item.w.z_low;  d[5] = item.w.z_high;
        if (^tb) begin
            res[0] = '0;
            res[0].kind = KIND_PARITY;
            n = 1;
        end else begin
            tc = tb[2:1];
            tag = tb[7:3];
            if (!cnt_started) begin
                sample_cnt = {30'd0, tc};
                released_cnt = {30'd0, tc};
                cnt_started = 1'b1;
            end
            if (tc != sample_cnt[1:0]) begin
                if (tc < sample_cnt[1:0]) sample_cnt = sample_cnt + 32'd4;
                sample_cnt = {sample_cnt[31:2], tc};
            end
            lag = comp_on ? 32'd2 : 32'd0;
            while (n < SLOT_COUNT && (sample_cnt - released_cnt) > lag) begin
                s = released_cnt[SLOT_BITS-1:0];
                res[n] = '0;
                res[n].kind = KIND_SAMPLE;
                res[n].sample_index = index_s[s];
                res[n].acc_x = axes[0][s][0];
                res[n].acc_y = axes[0][s][1];
                res[n].acc_z = axes[0][s][2];
                res[n].gyro_x = axes[1][s][0];
                res[n].gyro_y = axes[1][s][1];
                res[n].gyro_z = axes[1][s][2];
                res[n].temp_raw = temp_s[s];
                res[n].stamp = stamp_s[s];
                res[n].extras_valid = flags_s[s];
                temp_s[s] = '0;
                stamp_s[s] = '0;
                index_s[s] = '0;
                flags_s[s] = '0;
                // keep axes as delta bases while compression is on
                if (!comp_on) begin
                    for (int a = 0; a < 3; a++) begin
                        axes[0][s][a] = AXIS_DEFAULT;
                        axes[1][s][a] = AXIS_DEFAULT;
                    end
                end
                released_cnt = released_cnt + 32'd1;
                n++;
            end
            t = tc;
            t1 = (t + SLOT_COUNT - 1) % SLOT_COUNT;
            t2 = (t + SLOT_COUNT - 2) % SLOT_COUNT;
            t3 = (t + SLOT_COUNT - 3) % SLOT_COUNT;
            k = (tag == TAG_GYRO || tag == TAG_GYRO_T2 || tag == TAG_GYRO_T1 ||
                 tag == TAG_GYRO_2X8 || tag == TAG_GYRO_3X5) ? 1 : 0;
            kind = KIND_SAMPLE;
            case (tag)
                TAG_GYRO, TAG_ACC: load_plain(k, t, d, sample_cnt);
                TAG_TEMP: begin
                    temp_s[t] = {d[1], d[0]};
                    flags_s[t][1] = 1'b1;
                end
                TAG_TIME: begin
                    ts = {d[3], d[2], d[1], d[0]};
                    if (stamp_ext[31:0] > ts) stamp_ext = stamp_ext + 64'h1_0000_0000;
                    stamp_ext = {stamp_ext[63:32], ts};
                    stamp_s[t] = stamp_ext;
                    flags_s[t][0] = 1'b1;
                end
                TAG_CFG: comp_on = d[3][7];
                TAG_ACC_T2, TAG_GYRO_T2: load_plain(k, t2, d, sample_cnt - 32'd2);
                TAG_ACC_T1, TAG_GYRO_T1: load_plain(k, t1, d, sample_cnt - 32'd1);
                TAG_ACC_2X8, TAG_GYRO_2X8: begin
                    for (int a = 0; a < 3; a++) axes[k][t2][a] = axes[k][t3][a] + ext8(d[a]);
                    index_s[t2] = sample_cnt - 32'd2;
                    for (int a = 0; a < 3; a++) axes[k][t1][a] = axes[k][t2][a] + ext8(d[a+3]);
                    index_s[t1] = sample_cnt - 32'd1;
                end
                TAG_ACC_3X5, TAG_GYRO_3X5: begin
                    add5(k, t2, t3, d[1], d[0]);
                    index_s[t2] = sample_cnt - 32'd2;
                    add5(k, t1, t2, d[3], d[2]);
                    index_s[t1] = sample_cnt - 32'd1;
                    add5(k, t, t1, d[5], d[4]);
                    index_s[t] = sample_cnt;
                end
                default: begin
                    if ((tag >= TAG_NI_FIRST && tag <= TAG_NI_LAST) || tag == TAG_NI_EXTRA)
                        kind = KIND_NOT_IMPL;
                    else
                        kind = KIND_UNKNOWN;
                end
            endcase
            if (kind != KIND_SAMPLE) begin
                res[n] = '0;
                res[n].kind = kind;
                n++;
            end
        end
        if (n > 0) begin
            res[n-1].last = 1'b1;
            if (item.typed) res[n-1].kind = item.tk;
        end
        for (int i = 0; i < n; i++) sample_q.push_back(res[i]);
    endtask

    function automatic t_in_item make_word(input logic [4:0] tag, input logic [1:0] cnt,
                                           input logic [47:0] data, input logic bad);
        return {tag, cnt, ^{tag, cnt} ^ bad, data};
    endfunction

    task automatic push_word(input t_in_item w, input logic typed, input logic [1:0] tk);
        t_word item;
        item.w = w;
        item.typed = typed;
        item.tk = tk;
        word_q.push_back(item);
    endtask

    task automatic wait_idle();
        while (word_q.size() != 0 || in_valid || sample_q.size() != 0) @(posedge i_clk);
        // a word may release nothing; let the sequencer settle
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_comp_start(input logic val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_COMP_AT_START);
        pwdata <= {31'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        comp_on = val;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (sample_q.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, got);
            fails++;
        end else begin
            want = sample_q.pop_front();
            if (got.kind != want.kind)
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            if (got.sample_index != want.sample_index)
                $display("%0t: sample_index expected %h actual %h", $time,
                         want.sample_index, got.sample_index);
            if ({got.acc_x, got.acc_y, got.acc_z} != {want.acc_x, want.acc_y, want.acc_z})
                $display("%0t: acc expected %h %h %h actual %h %h %h", $time,
                         want.acc_x, want.acc_y, want.acc_z, got.acc_x, got.acc_y, got.acc_z);
            if ({got.gyro_x, got.gyro_y, got.gyro_z} != {want.gyro_x, want.gyro_y, want.gyro_z})
                $display("%0t: gyro expected %h %h %h actual %h %h %h", $time, want.gyro_x,
                         want.gyro_y, want.gyro_z, got.gyro_x, got.gyro_y, got.gyro_z);
            if (got.temp_raw != want.temp_raw)
                $display("%0t: temp_raw expected %h actual %h", $time, want.temp_raw, got.temp_raw);
            if (got.stamp != want.stamp)
                $display("%0t: stamp expected %h actual %h", $time, want.stamp, got.stamp);
            if (got.extras_valid != want.extras_valid)
                $display("%0t: extras_valid expected %0d actual %0d", $time,
                         want.extras_valid, got.extras_valid);
            if (got.last != want.last)
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            if (got !== want) fails++;
        end
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // word sender: hold valid and payload until the transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) decode_word(word_q.pop_front());
            if (!in_valid || o_in_ready) begin
                if (word_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    in_data <= word_q[0].w;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && out_ready) check_result(o_out_data);
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial begin
        logic [1:0]  cnt;
        logic [4:0]  tag;
        logic [47:0] data;
        int          pick;
        reset_image();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NROWS; r++)
            push_word(make_word(DIR_ROWS[r].tag, DIR_ROWS[r].cnt, DIR_ROWS[r].data,
                                DIR_ROWS[r].bad), DIR_ROWS[r].typed, DIR_ROWS[r].tk);

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_comp_start(ph % 2 == 0);
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 78; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 78; end
                default: begin send_idle = 15; recv_stall = 15; end
            endcase
            cnt = 2'($urandom_range(3));
            for (int i = 0; i < 125; i++) begin
                // mostly well-formed runs; some jumps, stray tags and bad parity
                pick = $urandom_range(99);
                if (pick < 70) cnt = cnt + 2'($urandom_range(1));
                else if (pick < 80) cnt = 2'($urandom_range(3));
                data = {$urandom, 16'($urandom)};
                pick = $urandom_range(99);
                if (pick < 85) tag = 5'($urandom_range(TAG_GYRO_3X5, TAG_GYRO));
                else tag = 5'($urandom_range(31));
                push_word(make_word(tag, cnt, data, $urandom_range(99) < 5), 1'b0, KIND_SAMPLE);
            end
        end

        while (word_q.size() != 0 || in_valid || sample_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fails == 0 && sample_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
